>>> hw/rtl/triangle_sides_perimeter_area_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle block port checks
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SIDES_PERIMETER_AREA_MACROS_SVH
`define TRIANGLE_SIDES_PERIMETER_AREA_MACROS_SVH

// Same-cycle implication, masked during reset
`define TSPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset
`define TSPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tspa_pkg.sv
// ----------------------------------------------------------------------------
// tspa_pkg
// Widths shared by the triangle sides, perimeter and area pipeline.
// ----------------------------------------------------------------------------
package tspa_pkg;

  localparam int COORD_W    = 16;
  localparam int SIDE_W     = 17;
  localparam int PERIM_W    = 19;
  localparam int AREA_W     = 32;
  localparam int SIDE_RAD_W = 2 * SIDE_W;   // squared distance, padded to even
  localparam int AREA_RAD_W = 4 * PERIM_W;  // Heron product
  localparam int FACT_W     = PERIM_W;      // one Heron factor
  localparam int HALF_W     = FACT_W;       // half of a factor pair product
  localparam int IN_W       = 6 * COORD_W;
  localparam int OUT_RAW_W  = 3 * SIDE_W + PERIM_W + AREA_W;
  localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;

endpackage

>>> hw/rtl/tspa_sqrt.sv
// ----------------------------------------------------------------------------
// tspa_sqrt
// Pipelined floor square root over N lanes, one result bit per stage.
// ----------------------------------------------------------------------------
module tspa_sqrt #(
  parameter int W = 34,
  parameter int N = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [W-1:0]         in_rad [N],
  output logic                 out_valid,
  output logic [W/2-1:0]       out_root [N]
);

  localparam int R = W / 2;

  logic           vld_q  [R];
  logic [R+1:0]   rem_q  [R][N];
  logic [R-1:0]   root_q [R][N];
  logic [W-1:0]   rad_q  [R][N];

  for (genvar k = 0; k < R; k++) begin : g_stage
    logic         src_vld;
    logic [R+1:0] src_rem  [N];
    logic [R-1:0] src_root [N];
    logic [W-1:0] src_rad  [N];

    // Select the stage source: the ports for the first stage, else the previous stage
    if (k == 0) begin : g_first
      assign src_vld = in_valid;
      always_comb begin
        for (int i = 0; i < N; i++) begin
          src_rem[i]  = '0;
          src_root[i] = '0;
          src_rad[i]  = in_rad[i];
        end
      end
    end else begin : g_next
      assign src_vld = vld_q[k-1];
      always_comb begin
        for (int i = 0; i < N; i++) begin
          src_rem[i]  = rem_q[k-1][i];
          src_root[i] = root_q[k-1][i];
          src_rad[i]  = rad_q[k-1][i];
        end
      end
    end

    for (genvar l = 0; l < N; l++) begin : g_lane
      logic [R+3:0] acc;
      logic [R+3:0] trial;
      logic [R+3:0] diff;
      logic         ge;

      // Bring down two radicand bits and try the next root bit
      assign acc   = {src_rem[l], src_rad[l][W-1 -: 2]};
      assign trial = {2'b00, src_root[l], 2'b01};
      assign diff  = acc - trial;
      assign ge    = (acc >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k][l]  <= ge ? diff[R+1:0] : acc[R+1:0];
          root_q[k][l] <= {src_root[l][R-2:0], ge};
          rad_q[k][l]  <= src_rad[l] << 2;
        end
      end
    end

    // Advance the valid bit with the data
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= src_vld;
      end
    end
  end

  assign out_valid = vld_q[R-1];
  always_comb begin
    for (int i = 0; i < N; i++) begin
      out_root[i] = root_q[R-1][i];
    end
  end

endmodule

>>> hw/rtl/triangle_sides_perimeter_area.sv
// The path from input request to result runs through 3 distance stages,
// 17 side root stages, 5 Heron product stages, 38 area root stages and
// the result register.
// Throughput: one request per cycle; the whole pipe holds while the result
// register is full and not taken.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// triangle_sides_perimeter_area
// Side lengths, perimeter and Heron area of a triangle given as three points.
// ----------------------------------------------------------------------------
module triangle_sides_perimeter_area import tspa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // side_ab, side_bc, side_ca, perimeter, area, zero pad
  output logic [OUT_W-1:0] m_tdata
);

  localparam int PAY_W  = 3 * SIDE_W + PERIM_W + 1;
  localparam int DLY_N  = AREA_RAD_W / 2;
  localparam int ROOT_W = AREA_RAD_W / 2;

  logic en;

  // Hold the whole pipe while the result waits
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] p,
                                                  input logic [COORD_W-1:0] q);
    logic signed [COORD_W:0] d;
    logic        [COORD_W:0] m;
    d = $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

  logic [COORD_W-1:0] ax, ay, bx, by, cx, cy;
  assign ax = s_tdata[0*COORD_W +: COORD_W];
  assign ay = s_tdata[1*COORD_W +: COORD_W];
  assign bx = s_tdata[2*COORD_W +: COORD_W];
  assign by = s_tdata[3*COORD_W +: COORD_W];
  assign cx = s_tdata[4*COORD_W +: COORD_W];
  assign cy = s_tdata[5*COORD_W +: COORD_W];

  // Stage 1: absolute coordinate differences
  logic               s1_vld;
  logic [COORD_W-1:0] s1_d [6];
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_d[0] <= abs_diff(bx, ax);
      s1_d[1] <= abs_diff(by, ay);
      s1_d[2] <= abs_diff(cx, bx);
      s1_d[3] <= abs_diff(cy, by);
      s1_d[4] <= abs_diff(ax, cx);
      s1_d[5] <= abs_diff(ay, cy);
    end
  end

  // Stage 2: squares
  logic                 s2_vld;
  logic [2*COORD_W-1:0] s2_sq [6];
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        s2_sq[i] <= s1_d[i] * s1_d[i];
      end
    end
  end

  // Stage 3: squared distances
  logic                  s3_vld;
  logic [SIDE_RAD_W-1:0] s3_rad [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_rad[i] <= SIDE_RAD_W'(s2_sq[2*i]) + SIDE_RAD_W'(s2_sq[2*i+1]);
      end
    end
  end

  // Side roots
  logic              side_vld;
  logic [SIDE_W-1:0] side [3];
  tspa_sqrt #(.W(SIDE_RAD_W), .N(3)) u_side_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_vld),
    .in_rad    (s3_rad),
    .out_valid (side_vld),
    .out_root  (side)
  );

  // Stage 4: perimeter and the other three Heron factors
  logic                     s4_vld;
  logic [SIDE_W-1:0]        s4_side [3];
  logic [PERIM_W-1:0]       s4_per;
  logic signed [FACT_W-1:0] s4_f [3];
  logic [PERIM_W-1:0]       per_sum;
  assign per_sum = PERIM_W'(side[0]) + PERIM_W'(side[1]) + PERIM_W'(side[2]);
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= side_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_side <= side;
      s4_per  <= per_sum;
      s4_f[0] <= $signed(FACT_W'(side[1]) + FACT_W'(side[2]) - FACT_W'(side[0]));
      s4_f[1] <= $signed(FACT_W'(side[0]) + FACT_W'(side[2]) - FACT_W'(side[1]));
      s4_f[2] <= $signed(FACT_W'(side[0]) + FACT_W'(side[1]) - FACT_W'(side[2]));
    end
  end

  // Stage 5: factor pair products; mark the area to be dropped when a factor is not positive
  logic                 s5_vld;
  logic [PAY_W-1:0]     s5_pay;
  logic [2*FACT_W-1:0]  s5_p1, s5_p2;
  logic                 pos;
  assign pos = (s4_f[0] > 0) && (s4_f[1] > 0) && (s4_f[2] > 0);
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= s4_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_pay <= {pos, s4_per, s4_side[2], s4_side[1], s4_side[0]};
      s5_p1  <= s4_per * $unsigned(s4_f[0]);
      s5_p2  <= $unsigned(s4_f[1]) * $unsigned(s4_f[2]);
    end
  end

  // Stage 6: partial products of the wide product
  logic                s6_vld;
  logic [PAY_W-1:0]    s6_pay;
  logic [2*HALF_W-1:0] s6_ll, s6_lh, s6_hl, s6_hh;
  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= s5_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_pay <= s5_pay;
      s6_ll  <= s5_p1[HALF_W-1:0]        * s5_p2[HALF_W-1:0];
      s6_lh  <= s5_p1[HALF_W-1:0]        * s5_p2[2*HALF_W-1:HALF_W];
      s6_hl  <= s5_p1[2*HALF_W-1:HALF_W] * s5_p2[HALF_W-1:0];
      s6_hh  <= s5_p1[2*HALF_W-1:HALF_W] * s5_p2[2*HALF_W-1:HALF_W];
    end
  end

  // Stage 7: middle sum
  logic                s7_vld;
  logic [PAY_W-1:0]    s7_pay;
  logic [2*HALF_W:0]   s7_mid;
  logic [2*HALF_W-1:0] s7_ll, s7_hh;
  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (en) begin
      s7_vld <= s6_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_pay <= s6_pay;
      s7_mid <= {1'b0, s6_lh} + {1'b0, s6_hl};
      s7_ll  <= s6_ll;
      s7_hh  <= s6_hh;
    end
  end

  // Stage 8: full Heron product, zero when the factors do not all pass
  logic                  s8_vld;
  logic [PAY_W-1:0]      s8_pay;
  logic [AREA_RAD_W-1:0] s8_prod [1];
  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else if (en) begin
      s8_vld <= s7_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_pay     <= s7_pay;
      s8_prod[0] <= s7_pay[PAY_W-1]
                    ? ({s7_hh, s7_ll} + (AREA_RAD_W'(s7_mid) << HALF_W)) : '0;
    end
  end

  // Area root
  logic              root_vld;
  logic [ROOT_W-1:0] root [1];
  tspa_sqrt #(.W(AREA_RAD_W), .N(1)) u_area_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s8_vld),
    .in_rad    (s8_prod),
    .out_valid (root_vld),
    .out_root  (root)
  );

  // Delay the sides and perimeter alongside the area root
  logic [PAY_W-1:0] dly [DLY_N];
  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= s8_pay;
      for (int i = 1; i < DLY_N; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  // Result register: scale the root, saturate and pack
  logic [ROOT_W-3:0] area_q;
  logic [AREA_W-1:0] area_sat;
  assign area_q   = root[0][ROOT_W-1:2];
  assign area_sat = (|area_q[ROOT_W-3:AREA_W]) ? '1 : area_q[AREA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= root_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= OUT_W'({area_sat, dly[DLY_N-1][PAY_W-2:0]});
    end
  end

endmodule

>>> hw/rtl/tspa_checker.sv
// ----------------------------------------------------------------------------
// tspa_assert
// Port-level checks on the triangle block, bound to the top level.
// ----------------------------------------------------------------------------
`include "triangle_sides_perimeter_area_macros.svh"

module tspa_assert import tspa_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [SIDE_W-1:0]  ab, bc, ca;
  logic [PERIM_W-1:0] per;
  logic [PERIM_W-1:0] side_sum;
  logic [AREA_W-1:0]  area;
  logic               in_req;

  assign ab       = m_tdata[0*SIDE_W +: SIDE_W];
  assign bc       = m_tdata[1*SIDE_W +: SIDE_W];
  assign ca       = m_tdata[2*SIDE_W +: SIDE_W];
  assign per      = m_tdata[3*SIDE_W +: PERIM_W];
  assign area     = m_tdata[3*SIDE_W + PERIM_W +: AREA_W];
  assign side_sum = PERIM_W'(ab) + PERIM_W'(bc) + PERIM_W'(ca);
  assign in_req   = s_tvalid && s_tready;

  `TSPA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
  `TSPA_ASSERT_NOW(a_per, m_tvalid, per == side_sum, "perimeter mismatch")
  `TSPA_ASSERT_NOW(a_flat, m_tvalid && (ab == '0 || bc == '0 || ca == '0), area == '0, "flat area")
  `TSPA_ASSERT_NOW(a_ready, m_tready || !m_tvalid || in_req, s_tready, "input blocked")

endmodule

bind triangle_sides_perimeter_area tspa_assert u_tspa_assert (.*);

>>> test/tspa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tspa_checker
// Watches both stream channels of the triangle block, computes the expected
// sides, perimeter and Heron area for every accepted request, and compares
// each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tspa_checker import tspa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               errors,
  output int               pending
);

  typedef struct packed {
    logic [AREA_W-1:0]  area;
    logic [PERIM_W-1:0] perimeter;
    logic [SIDE_W-1:0]  side_ca;
    logic [SIDE_W-1:0]  side_bc;
    logic [SIDE_W-1:0]  side_ab;
  } tri_result_t;

  tri_result_t tri_expected_q[$];

  // Floor square root by bit-by-bit trial
  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  t;
    r = '0;
    for (int bit_i = 39; bit_i >= 0; bit_i--) begin
      t = r | (64'd1 << bit_i);
      if (128'(t) * 128'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [SIDE_W-1:0] side_len(input logic signed [15:0] x0,
      input logic signed [15:0] y0, input logic signed [15:0] x1,
      input logic signed [15:0] y1);
    longint dx;
    longint dy;
    dx = longint'(x1) - longint'(x0);
    dy = longint'(y1) - longint'(y0);
    return SIDE_W'(floor_sqrt(128'(dx * dx + dy * dy)));
  endfunction

  function automatic tri_result_t triangle_of(input logic [IN_W-1:0] d);
    tri_result_t r;
    longint a, b, c, f2, f3, f4;
    logic [127:0] prod;
    logic [63:0]  root;
    r.side_ab = side_len(d[15:0], d[31:16], d[47:32], d[63:48]);
    r.side_bc = side_len(d[47:32], d[63:48], d[79:64], d[95:80]);
    r.side_ca = side_len(d[79:64], d[95:80], d[15:0], d[31:16]);
    a = r.side_ab; b = r.side_bc; c = r.side_ca;
    r.perimeter = PERIM_W'(a + b + c);
    f2 = -a + b + c; f3 = a - b + c; f4 = a + b - c;
    r.area = '0;
    if (a + b + c > 0 && f2 > 0 && f3 > 0 && f4 > 0) begin
      prod = 128'(a + b + c) * 128'(f2) * 128'(f3) * 128'(f4);
      root = floor_sqrt(prod) >> 2;
      r.area = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("error: %s got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    tri_result_t got;
    tri_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) tri_expected_q.push_back(triangle_of(s_tdata));
      if (m_tvalid && m_tready) begin
        got = tri_result_t'(m_tdata[OUT_RAW_W-1:0]);
        if (tri_expected_q.size() == 0) begin
          report_mismatch("unexpected result, side_ab", got.side_ab, -1);
        end else begin
          want = tri_expected_q.pop_front();
          if (got.side_ab != want.side_ab)
            report_mismatch("side_ab", got.side_ab, want.side_ab);
          if (got.side_bc != want.side_bc)
            report_mismatch("side_bc", got.side_bc, want.side_bc);
          if (got.side_ca != want.side_ca)
            report_mismatch("side_ca", got.side_ca, want.side_ca);
          if (got.perimeter != want.perimeter)
            report_mismatch("perimeter", got.perimeter, want.perimeter);
          if (got.area != want.area)
            report_mismatch("area", got.area, want.area);
        end
      end
      pending = tri_expected_q.size();
    end
  end

endmodule

>>> test/tb_triangle_sides_perimeter_area.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_sides_perimeter_area
// Drives directed and random triangles into the block with random gaps and
// result stalls, including one long stall that backs up the pipe; the
// checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_triangle_sides_perimeter_area;
  import tspa_pkg::*;

  localparam int TRI_COUNT   = 1300;
  localparam int CYCLE_LIMIT = 200000;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  int               errors;
  int               pending;
  int               cycle_count;
  bit               hold_long;
  bit               sent_all;
  bit               timed_out;

  logic [15:0] tri_points[$][6];

  triangle_sides_perimeter_area DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  tspa_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Draw a coordinate: small, full range or an extreme, each a third of the time
  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2, 3: return 16'($urandom_range(0, 200)) - 16'd100;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_tri(input logic [15:0] ax, ay, bx, by, cx, cy);
    logic [15:0] p[6];
    p = '{ax, ay, bx, by, cx, cy};
    tri_points.push_back(p);
  endtask

  // Build the directed list, then random triangles
  initial begin
    logic [15:0] ox;
    logic [15:0] oy;
    add_tri(0, 0, 0, 0, 0, 0);
    add_tri(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    add_tri(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_tri(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 0, 16'h7FFF);
    add_tri(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_tri(0, 0, 48, 0, 0, 64);
    add_tri(0, 0, 16, 0, 32, 0);
    add_tri(0, 0, 1, 1, 2, 2);
    add_tri(0, 0, 1, 0, 0, 1);
    add_tri(5, 5, 5, 5, 100, 7);
    add_tri(16'h8000, 0, 16'h7FFF, 0, 0, 1);
    add_tri(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h1234, 16'hEDCB);
    add_tri(0, 0, 160, 0, 80, 139);
    add_tri(16'hFF00, 16'h0100, 16'h0100, 16'hFF00, 16'h7FFF, 16'h8000);
    add_tri(3, 0, 0, 4, 0, 0);
    for (int i = 0; i < TRI_COUNT; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        // Skinny or near-degenerate triangles around a random origin
        ox = rand_coord(); oy = rand_coord();
        add_tri(ox, oy, ox + 16'($urandom_range(0, 3)), oy + 16'($urandom_range(0, 3)),
                ox + 16'($urandom_range(0, 6)), oy + 16'($urandom_range(0, 6)));
      end else begin
        add_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord());
      end
    end
  end

  // Reset and stimulus
  initial begin
    int gap;
    logic [15:0] p[6];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sent_all = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < tri_points.size(); i++) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      if (i > 200 && i < 400) gap = 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      p = tri_points[i];
      s_tvalid <= 1'b1;
      s_tdata <= {p[5], p[4], p[3], p[2], p[1], p[0]};
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 1'b0;
    sent_all = 1'b1;
  end

  // Long receiver hold-off once the pipe is busy
  initial begin
    hold_long = 1'b0;
    repeat (300) @(posedge clk);
    hold_long = 1'b1;
    repeat (200) @(posedge clk);
    hold_long = 1'b0;
  end

  // Result stalls: draw a wait per result, with calm stretches
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      if (stall > 0 || hold_long) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_long) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Verdict after draining, plus a cycle limit
  initial begin
    cycle_count = 0;
    timed_out = 1'b0;
    fork
      begin
        wait (sent_all);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk);
          cycle_count++;
        end
        timed_out = 1'b1;
        $display("timeout");
      end
    join_any
    if (errors == 0 && !timed_out)
      $display("triangle_sides_perimeter_area: match");
    else
      $display("triangle_sides_perimeter_area: mismatch");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tspa_pkg.sv
hw/rtl/tspa_sqrt.sv
hw/rtl/triangle_sides_perimeter_area.sv
hw/rtl/tspa_checker.sv
test/tspa_checker.sv
test/tb_triangle_sides_perimeter_area.sv
